/* rtl/pjma_pkg.sv */
// Package with the shared constants of the per-joint moving average.
`default_nettype none

package pjma_pkg;

    // Width of the joint index field on both channels.
    localparam int JOINT_W = 4;

    // Number of coordinate axes carried by one item.
    localparam int AXES = 3;

endpackage

`default_nettype wire

/* rtl/pjma_if.sv */
// Valid/ready channel interfaces for joint samples and smoothed results.
`default_nettype none

// Input channel: one joint sample per item.
interface pjma_in_if #(
    parameter int COORD_BITS = 20
);
    logic                                valid;
    logic                                ready;
    logic        [pjma_pkg::JOINT_W-1:0] joint_index;
    logic signed [COORD_BITS-1:0]        sample_x;
    logic signed [COORD_BITS-1:0]        sample_y;
    logic signed [COORD_BITS-1:0]        sample_z;

    modport source (
        output valid, joint_index, sample_x, sample_y, sample_z,
        input  ready
    );

    modport sink (
        input  valid, joint_index, sample_x, sample_y, sample_z,
        output ready
    );
endinterface

// Output channel: one smoothed joint position per item.
interface pjma_out_if #(
    parameter int COORD_BITS = 20
);
    logic                                valid;
    logic                                ready;
    logic        [pjma_pkg::JOINT_W-1:0] out_joint;
    logic signed [COORD_BITS-1:0]        avg_x;
    logic signed [COORD_BITS-1:0]        avg_y;
    logic signed [COORD_BITS-1:0]        avg_z;

    modport source (
        output valid, out_joint, avg_x, avg_y, avg_z,
        input  ready
    );

    modport sink (
        input  valid, out_joint, avg_x, avg_y, avg_z,
        output ready
    );
endinterface

`default_nettype wire

/* rtl/per_joint_moving_average.sv */
// Per-joint boxcar moving average of 3D skeleton joint positions.
//
// Samples arrive on i_in, one joint and one x, y, z triple per item. Each
// item yields exactly one item on o_out: the joint index and, per axis, the
// sum of that joint's last WINDOW samples divided by WINDOW, truncated
// toward zero. An index of JOINTS or above changes no state and returns
// zero averages.
// The block is a four-stage pipeline: window memory read, running-sum
// update, reciprocal multiply, quotient correction into the output register.
// One item is accepted every cycle while the receiver does not stall the
// output; the figure is set by the single read-modify-write of the window
// memory and the sum registers per item.
// Synchronous active-low reset clears the sums, the write positions, the
// slot valid bits and the pipeline; slots never written read as zero, so a
// joint's first WINDOW-1 results are partial sums divided by WINDOW.
// When the receiver stalls, the output item holds and the pipeline fills
// behind it; i_in.ready falls only once every stage is occupied.
`default_nettype none

module per_joint_moving_average #(
    parameter int JOINTS     = 15,
    parameter int WINDOW     = 3,
    parameter int COORD_BITS = 20
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    pjma_in_if.sink      i_in,
    pjma_out_if.source   o_out
);

    localparam int JW      = pjma_pkg::JOINT_W;
    localparam int AX      = pjma_pkg::AXES;
    localparam int POS_W   = $clog2(WINDOW);
    localparam int SUM_W   = COORD_BITS + $clog2(WINDOW);
    localparam int JIDX_W  = (JOINTS > 1) ? $clog2(JOINTS) : 1;
    localparam int SLOTS   = JOINTS * WINDOW;
    localparam int ADDR_W  = $clog2(SLOTS);
    localparam int MEM_W   = AX * COORD_BITS;
    localparam int RECIP_K = SUM_W - 1;
    localparam int PROD_W  = SUM_W + RECIP_K;
    localparam logic [RECIP_K-1:0] RECIP = RECIP_K'((64'd1 << RECIP_K) / WINDOW);

    // Pipeline handshake signals.
    logic in_ready;
    logic accept;
    logic s1_adv;
    logic s2_adv;
    logic s3_adv;

    // Per-joint state.
    logic        [POS_W-1:0] r_wpos  [JOINTS];
    logic signed [SUM_W-1:0] r_sum   [JOINTS][AX];
    logic        [SLOTS-1:0] r_slot_vld;
    logic        [MEM_W-1:0] r_mem   [SLOTS];

    // Input decode.
    logic [JIDX_W+JW-1:0] in_jext;
    logic [JIDX_W-1:0]    in_jidx;
    logic                 in_range;
    logic [POS_W-1:0]     in_pos;
    logic [ADDR_W-1:0]    rd_addr;

    // Stage 1: sample, memory read data and slot address.
    logic                         r_s1_v;
    logic        [JW-1:0]         r_s1_joint;
    logic        [JIDX_W-1:0]     r_s1_jidx;
    logic                         r_s1_inr;
    logic        [ADDR_W-1:0]     r_s1_addr;
    logic signed [COORD_BITS-1:0] r_s1_smp [AX];
    logic        [MEM_W-1:0]      r_rd_data;
    logic                         r_rd_vld;
    logic signed [SUM_W-1:0]      s1_sum   [AX];

    // Stage 2: updated sums.
    logic                    r_s2_v;
    logic [JW-1:0]           r_s2_joint;
    logic signed [SUM_W-1:0] r_s2_sum [AX];
    logic [SUM_W-1:0]        s2_mag   [AX];
    logic [SUM_W-1:0]        s2_q     [AX];

    // Stage 3: magnitude, quotient estimate and sign.
    logic                    r_s3_v;
    logic [JW-1:0]           r_s3_joint;
    logic [SUM_W-1:0]        r_s3_mag [AX];
    logic [SUM_W-1:0]        r_s3_q   [AX];
    logic [AX-1:0]           r_s3_neg;
    logic signed [COORD_BITS-1:0] s3_avg [AX];

    // Output register.
    logic                         r_o_v;
    logic [JW-1:0]                r_o_joint;
    logic signed [COORD_BITS-1:0] r_o_avg [AX];

    // Each stage moves on when the one after it is empty or moving.
    always_comb begin
        s3_adv   = r_s3_v && (!r_o_v || o_out.ready);
        s2_adv   = r_s2_v && (!r_s3_v || s3_adv);
        s1_adv   = r_s1_v && (!r_s2_v || s2_adv);
        in_ready = !r_s1_v || s1_adv;
        accept   = i_in.valid && in_ready;
    end

    assign i_in.ready = in_ready;

    // Decode the joint index, its write position and the slot to read.
    always_comb begin
        in_jext  = {{JIDX_W{1'b0}}, i_in.joint_index};
        in_jidx  = in_jext[JIDX_W-1:0];
        in_range = 32'(i_in.joint_index) < 32'(JOINTS);
        in_pos   = in_range ? r_wpos[in_jidx] : '0;
        rd_addr  = ADDR_W'(32'(in_jidx) * 32'(WINDOW) + 32'(in_pos));
    end

    // Valid flags of the pipeline stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
            r_o_v  <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_v <= 1'b1;
            end else if (s1_adv) begin
                r_s1_v <= 1'b0;
            end
            if (s1_adv) begin
                r_s2_v <= 1'b1;
            end else if (s2_adv) begin
                r_s2_v <= 1'b0;
            end
            if (s2_adv) begin
                r_s3_v <= 1'b1;
            end else if (s3_adv) begin
                r_s3_v <= 1'b0;
            end
            if (s3_adv) begin
                r_o_v <= 1'b1;
            end else if (o_out.ready) begin
                r_o_v <= 1'b0;
            end
        end
    end

    // The write position advances as the item is accepted, so the next item
    // of the same joint already addresses the following slot.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < JOINTS; j++) begin
                r_wpos[j] <= '0;
            end
        end else if (accept && in_range) begin
            if (in_pos == POS_W'(WINDOW - 1)) begin
                r_wpos[in_jidx] <= '0;
            end else begin
                r_wpos[in_jidx] <= in_pos + 1'b1;
            end
        end
    end

    // Window memory: read at acceptance, written as stage 1 moves on.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd_data <= r_mem[rd_addr];
        end
        if (s1_adv && r_s1_inr) begin
            r_mem[r_s1_addr] <= {r_s1_smp[2], r_s1_smp[1], r_s1_smp[0]};
        end
    end

    // Slot valid bits stand in for clearing the memory at reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_vld <= '0;
        end else if (s1_adv && r_s1_inr) begin
            r_slot_vld[r_s1_addr] <= 1'b1;
        end
    end

    // Stage 1 capture.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_joint  <= i_in.joint_index;
            r_s1_jidx   <= in_jidx;
            r_s1_inr    <= in_range;
            r_s1_addr   <= rd_addr;
            r_s1_smp[0] <= i_in.sample_x;
            r_s1_smp[1] <= i_in.sample_y;
            r_s1_smp[2] <= i_in.sample_z;
            r_rd_vld    <= in_range && r_slot_vld[rd_addr];
        end
    end

    // Running sum: drop the sample leaving the window, add the new one.
    always_comb begin
        logic signed [COORD_BITS-1:0] old_smp;
        for (int a = 0; a < AX; a++) begin
            old_smp = r_rd_vld ? signed'(r_rd_data[a*COORD_BITS +: COORD_BITS]) : '0;
            if (r_s1_inr) begin
                s1_sum[a] = r_sum[r_s1_jidx][a] - SUM_W'(old_smp) + SUM_W'(r_s1_smp[a]);
            end else begin
                s1_sum[a] = '0;
            end
        end
    end

    // Sum registers take the new sums as stage 1 moves on.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < JOINTS; j++) begin
                for (int a = 0; a < AX; a++) begin
                    r_sum[j][a] <= '0;
                end
            end
        end else if (s1_adv && r_s1_inr) begin
            for (int a = 0; a < AX; a++) begin
                r_sum[r_s1_jidx][a] <= s1_sum[a];
            end
        end
    end

    // Stage 2 capture.
    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_s2_joint <= r_s1_joint;
            for (int a = 0; a < AX; a++) begin
                r_s2_sum[a] <= s1_sum[a];
            end
        end
    end

    // Magnitude times the reciprocal gives the quotient or one less.
    always_comb begin
        logic [PROD_W-1:0] prod;
        for (int a = 0; a < AX; a++) begin
            s2_mag[a] = r_s2_sum[a][SUM_W-1] ? SUM_W'(-r_s2_sum[a]) : SUM_W'(r_s2_sum[a]);
            prod      = PROD_W'(s2_mag[a]) * PROD_W'(RECIP);
            s2_q[a]   = SUM_W'(prod >> RECIP_K);
        end
    end

    // Stage 3 capture.
    always_ff @(posedge i_clk) begin
        if (s2_adv) begin
            r_s3_joint <= r_s2_joint;
            for (int a = 0; a < AX; a++) begin
                r_s3_mag[a] <= s2_mag[a];
                r_s3_q[a]   <= s2_q[a];
                r_s3_neg[a] <= r_s2_sum[a][SUM_W-1];
            end
        end
    end

    // Correct the estimate by one where the remainder reaches the window
    // length, then restore the sign.
    always_comb begin
        logic [SUM_W-1:0] rem;
        logic [SUM_W-1:0] quo;
        for (int a = 0; a < AX; a++) begin
            rem = r_s3_mag[a] - SUM_W'(r_s3_q[a] * SUM_W'(WINDOW));
            quo = (rem >= SUM_W'(WINDOW)) ? r_s3_q[a] + 1'b1 : r_s3_q[a];
            s3_avg[a] = r_s3_neg[a] ? COORD_BITS'(-quo) : COORD_BITS'(quo);
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (s3_adv) begin
            r_o_joint <= r_s3_joint;
            for (int a = 0; a < AX; a++) begin
                r_o_avg[a] <= s3_avg[a];
            end
        end
    end

    assign o_out.valid     = r_o_v;
    assign o_out.out_joint = r_o_joint;
    assign o_out.avg_x     = r_o_avg[0];
    assign o_out.avg_y     = r_o_avg[1];
    assign o_out.avg_z     = r_o_avg[2];

endmodule

`default_nettype wire

/* rtl/pjma_chk.sv */
// Port-level checker for the per-joint moving average, bound to its top level.
`default_nettype none

module pjma_chk #(
    parameter int JOINTS     = 15,
    parameter int COORD_BITS = 20
) (
    input wire                          i_clk,
    input wire                          i_rst_n,
    input wire                          i_in_ready,
    input wire                          i_out_valid,
    input wire                          i_out_ready,
    input wire [pjma_pkg::JOINT_W-1:0]  i_out_joint,
    input wire [COORD_BITS-1:0]         i_avg_x,
    input wire [COORD_BITS-1:0]         i_avg_y,
    input wire [COORD_BITS-1:0]         i_avg_z
);

    // A stalled result item stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result item dropped while stalled");

    // A stalled result item keeps its payload.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_joint) && $stable(i_avg_x)
            && $stable(i_avg_y) && $stable(i_avg_z))
        else $error("result item changed while stalled");

    // With the output free to move, the whole pipeline moves and takes input.
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid || i_out_ready |-> i_in_ready)
        else $error("input stalled although the output is free");

    // Joints beyond the table give zero averages.
    a_bad_joint: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (32'(i_out_joint) >= 32'(JOINTS)) |->
            i_avg_x == '0 && i_avg_y == '0 && i_avg_z == '0)
        else $error("nonzero average for an unknown joint");

endmodule

bind per_joint_moving_average pjma_chk #(
    .JOINTS     (JOINTS),
    .COORD_BITS (COORD_BITS)
) u_pjma_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_joint (o_out.out_joint),
    .i_avg_x     (o_out.avg_x),
    .i_avg_y     (o_out.avg_y),
    .i_avg_z     (o_out.avg_z)
);

`default_nettype wire
